// ===== rtl/cap_pkg.sv =====
// Package: widths, constants and the arctangent table for the arc evaluator.
`timescale 1ns / 1ps
package cap_pkg;
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int AW = 36;
   localparam int CW = 33;
   localparam logic signed [AW-1:0] TWO_PI_Q27  = 36'sd843314857;
   localparam logic signed [AW-1:0] PI_Q27      = 36'sd421657428;
   localparam logic signed [AW-1:0] HALF_PI_Q27 = 36'sd210828714;
   localparam logic signed [CW-1:0] GAIN_Q30    = 33'sd652032874;
   localparam logic [1:0] OP_SYM = 2'd0;
   localparam logic [1:0] OP_FWD = 2'd1;
   localparam logic [1:0] OP_REV = 2'd2;
   localparam logic [1:0] OP_NONE = 2'd3;
   localparam logic [2:0] REG_CX = 3'd0;
   localparam logic [2:0] REG_CY = 3'd1;
   localparam logic [2:0] REG_R  = 3'd2;
   localparam logic [2:0] REG_AS = 3'd3;
   localparam logic [2:0] REG_AE = 3'd4;

   typedef struct packed {
      logic [1:0] op;
      logic signed [15:0] param_t;
      logic negate_tangent;
   } req_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] tangent_x;
      logic signed [31:0] tangent_y;
      logic [30:0] speed;
   } rsp_type;

   function automatic logic signed [AW-1:0] atan_step(input int i);
      logic signed [AW-1:0] r;
      unique case (i)
         0: r = 36'sd105414357;
         1: r = 36'sd62229729;
         2: r = 36'sd32880480;
         3: r = 36'sd16690645;
         4: r = 36'sd8377711;
         5: r = 36'sd4192939;
         6: r = 36'sd2096981;
         7: r = 36'sd1048555;
         8: r = 36'sd524285;
         9: r = 36'sd262144;
         default: r = (i <= 27) ? (36'sd1 <<< (27 - i)) : 36'sd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction
endpackage

// ===== rtl/cap_if.sv =====
// Interfaces: valid/ready channels for request and response transactions.
`timescale 1ns / 1ps
interface cap_req_if;
   import cap_pkg::*;
   logic valid;
   logic ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface cap_rsp_if;
   import cap_pkg::*;
   logic valid;
   logic ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/circular_arc_point_and_tangent_core.sv =====
// Top level: pipelined circular arc point, tangent and speed evaluator.
//  channel | dir | payload
//  req     | in  | op, param_t, negate_tangent
//  rsp     | out | point_x, point_y, tangent_x, tangent_y, speed
//  csr     | in  | wr_en, index, 32-bit data
// One transaction per cycle is sustained while the response is not stalled.
// The pipeline depth is set by one CORDIC iteration per stage plus the angle, reduction, multiplier and output stages.
// Reset clears the valid bits and loads register defaults.
// A stalled response holds the whole pipeline; nothing is lost or repeated.
`timescale 1ns / 1ps
module circular_arc_point_and_tangent_core #(
   parameter int CORDIC_STAGES = cap_pkg::CORDIC_STAGES_DEF
) (
   input  logic clock,
   input  logic reset,
   cap_req_if.sink req,
   cap_rsp_if.source rsp,
   input  logic csr_wr_en,
   input  logic [2:0] csr_index,
   input  logic [31:0] csr_data
);
   import cap_pkg::*;
   localparam int N = CORDIC_STAGES;

   logic signed [31:0] cx_ff, cy_ff;
   logic [30:0] r_ff;
   logic signed [15:0] as_ff, ae_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= '0; cy_ff <= '0; r_ff <= 31'd16384; as_ff <= '0; ae_ff <= 16'sd25736;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_CX: cx_ff <= csr_data;
            REG_CY: cy_ff <= csr_data;
            REG_R:  r_ff <= csr_data[30:0];
            REG_AS: as_ff <= csr_data[15:0];
            REG_AE: ae_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   logic adv;
   assign adv = !rsp.valid || rsp.ready;
   assign req.ready = adv;

   // stage A: angle, span
   logic va_ff, vr_ff, vb_ff, vc_ff, vd_ff;
   logic [1:0] opa_ff; logic nega_ff;
   logic signed [AW-1:0] ang_ff;
   logic signed [18:0] span_ff;
   logic signed [17:0] d_w;
   logic signed [18:0] span_in;
   logic signed [AW-1:0] base_in;
   always_comb begin
      d_w = 18'(ae_ff) - 18'(as_ff);
      unique case (req.data.op)
         OP_SYM: begin span_in = 19'(d_w);
            base_in = (AW'(as_ff) + AW'(ae_ff)) <<< 14; end
         OP_FWD: begin span_in = 19'(d_w) <<< 1; base_in = AW'(as_ff) <<< 15; end
         default: begin span_in = -(19'(d_w) <<< 1); base_in = AW'(ae_ff) <<< 15; end
      endcase
   end
   always_ff @(posedge clock) begin
      if (reset) va_ff <= 1'b0;
      else if (adv) va_ff <= req.valid;
      if (adv) begin
         opa_ff <= req.data.op; nega_ff <= req.data.negate_tangent;
         ang_ff <= AW'(req.data.param_t) * AW'(span_in) + base_in;
         span_ff <= span_in;
      end
   end

   // stage R: coarse reduction by 8 and 4 times 2pi (angle magnitude < 8*2pi)
   logic signed [AW-1:0] zr_w, zr_ff;
   logic [1:0] opr_ff; logic negr_ff; logic signed [18:0] spanr_ff;
   always_comb begin
      zr_w = ang_ff;
      for (int k = 3; k >= 2; k--) begin
         if (zr_w >= (TWO_PI_Q27 <<< k)) zr_w = zr_w - (TWO_PI_Q27 <<< k);
         if (zr_w < 0 && zr_w < -(TWO_PI_Q27 <<< k) + 1) zr_w = zr_w + (TWO_PI_Q27 <<< k);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) vr_ff <= 1'b0;
      else if (adv) vr_ff <= va_ff;
      if (adv) begin
         zr_ff <= zr_w; opr_ff <= opa_ff; negr_ff <= nega_ff; spanr_ff <= span_ff;
      end
   end

   // stage B: fine reduction mod 2pi and fold into [-pi/2, pi/2]
   logic signed [AW-1:0] z_w, zb_ff;
   logic flipb_ff;
   logic [1:0] opb_ff; logic negb_ff; logic signed [18:0] spanb_ff;
   logic flip_w;
   always_comb begin
      z_w = zr_ff;
      for (int k = 1; k >= 0; k--) begin
         if (z_w >= (TWO_PI_Q27 <<< k)) z_w = z_w - (TWO_PI_Q27 <<< k);
         if (z_w < 0 && z_w < -(TWO_PI_Q27 <<< k) + 1) z_w = z_w + (TWO_PI_Q27 <<< k);
      end
      if (z_w < 0) z_w = z_w + TWO_PI_Q27;
      if (z_w >= PI_Q27) z_w = z_w - TWO_PI_Q27;
      flip_w = 1'b0;
      if (z_w > HALF_PI_Q27) begin z_w = z_w - PI_Q27; flip_w = 1'b1; end
      else if (z_w < -HALF_PI_Q27) begin z_w = z_w + PI_Q27; flip_w = 1'b1; end
   end
   always_ff @(posedge clock) begin
      if (reset) vb_ff <= 1'b0;
      else if (adv) vb_ff <= vr_ff;
      if (adv) begin
         zb_ff <= z_w; flipb_ff <= flip_w; opb_ff <= opr_ff; negb_ff <= negr_ff;
         spanb_ff <= spanr_ff;
      end
   end

   // CORDIC stages
   logic v_ff [N+1];
   logic signed [CW-1:0] x_ff [N+1], y_ff [N+1];
   logic signed [AW-1:0] z_ff [N+1];
   logic fl_ff [N+1]; logic [1:0] op_ff [N+1]; logic ng_ff [N+1];
   logic signed [18:0] sp_ff [N+1];
   always_comb begin
      v_ff[0] = vb_ff; x_ff[0] = GAIN_Q30; y_ff[0] = '0; z_ff[0] = zb_ff;
      fl_ff[0] = flipb_ff; op_ff[0] = opb_ff; ng_ff[0] = negb_ff; sp_ff[0] = spanb_ff;
   end
   for (genvar i = 0; i < N; i++) begin : g_cordic
      always_ff @(posedge clock) begin
         if (reset) v_ff[i+1] <= 1'b0;
         else if (adv) v_ff[i+1] <= v_ff[i];
         if (adv) begin
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_step(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_step(i);
            end
            fl_ff[i+1] <= fl_ff[i]; op_ff[i+1] <= op_ff[i];
            ng_ff[i+1] <= ng_ff[i]; sp_ff[i+1] <= sp_ff[i];
         end
      end
   end

   // stage C: c, s, m and speed
   logic signed [CW-1:0] c_ff, s_ff;
   logic signed [50:0] m_ff;
   logic [1:0] opc_ff;
   logic [30:0] spd_ff;
   logic signed [50:0] m_w, mabs_w;
   logic signed [51:0] sp_w;
   always_comb begin
      m_w = 51'($signed({1'b0, r_ff})) * 51'(sp_ff[N]);
      mabs_w = m_w < 0 ? -m_w : m_w;
      sp_w = (52'(mabs_w) + 52'sd4096) >>> 13;
   end
   always_ff @(posedge clock) begin
      if (reset) vc_ff <= 1'b0;
      else if (adv) vc_ff <= v_ff[N];
      if (adv) begin
         c_ff <= fl_ff[N] ? -x_ff[N] : x_ff[N];
         s_ff <= fl_ff[N] ? -y_ff[N] : y_ff[N];
         m_ff <= (op_ff[N] == OP_REV && ng_ff[N]) ? -m_w : m_w;
         opc_ff <= op_ff[N];
         spd_ff <= (sp_w > 52'sd2147483647) ? 31'h7fffffff : sp_w[30:0];
      end
   end

   // stage D: partial products
   logic signed [63:0] pxr_ff, pyr_ff, hx_ff, lx_ff, hy_ff, ly_ff;
   logic [1:0] opd_ff; logic [30:0] spdd_ff;
   logic signed [26:0] mh_w;
   logic signed [25:0] ml_w;
   always_comb begin
      mh_w = m_ff[50:24];
      ml_w = $signed({2'b00, m_ff[23:0]});
   end
   always_ff @(posedge clock) begin
      if (reset) vd_ff <= 1'b0;
      else if (adv) vd_ff <= vc_ff;
      if (adv) begin
         pxr_ff <= 64'($signed({1'b0, r_ff})) * 64'(c_ff);
         pyr_ff <= 64'($signed({1'b0, r_ff})) * 64'(s_ff);
         hx_ff <= 64'(mh_w) * 64'(s_ff); lx_ff <= 64'(ml_w) * 64'(s_ff);
         hy_ff <= 64'(mh_w) * 64'(c_ff); ly_ff <= 64'(ml_w) * 64'(c_ff);
         opd_ff <= opc_ff; spdd_ff <= spd_ff;
      end
   end

   // stage E: round, saturate, output register
   logic signed [63:0] tx_w, ty_w, px_w, py_w;
   always_comb begin
      px_w = 64'(cx_ff) + ((pxr_ff + 64'sd536870912) >>> 30);
      py_w = 64'(cy_ff) + ((pyr_ff + 64'sd536870912) >>> 30);
      tx_w = -((hx_ff + ((lx_ff + (64'sd1 <<< 42)) >>> 24)) >>> 19);
      ty_w = (hy_ff + ((ly_ff + (64'sd1 <<< 42)) >>> 24)) >>> 19;
   end
   always_ff @(posedge clock) begin
      if (reset) rsp.valid <= 1'b0;
      else if (adv) rsp.valid <= vd_ff;
      if (adv) begin
         if (opd_ff == OP_NONE) rsp.data <= '0;
         else begin
            rsp.data.point_x <= sat32(px_w);
            rsp.data.point_y <= sat32(py_w);
            rsp.data.tangent_x <= sat32(tx_w);
            rsp.data.tangent_y <= sat32(ty_w);
            rsp.data.speed <= spdd_ff;
         end
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data)) else $error("rsp hold");
   a_none: assert property (@(posedge clock) disable iff (reset)
      adv && vd_ff && opd_ff == OP_NONE |=> rsp.data == '0) else $error("op3 not zero");
   a_spd: assert property (@(posedge clock) disable iff (reset)
      adv |=> !rsp.valid || rsp.data.speed == $past(spdd_ff) || $past(opd_ff) == OP_NONE)
      else $error("speed mismatch");
endmodule

// ===== sim/circular_arc_point_and_tangent_core_tb.sv =====
// Testbench: random and directed arc evaluations checked against a scoreboard model.
`timescale 1ns / 1ps
module circular_arc_point_and_tangent_core_tb;
   import cap_pkg::*;

   localparam int LAT = CORDIC_STAGES_DEF + 6;

   class arc_scoreboard;
      logic signed [63:0] cx, cy, rad, ast, aen;
      rsp_type pending[$];
      int errors;

      function new();
         cx = 0; cy = 0; rad = 16384; ast = 0; aen = 25736; errors = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] v);
         case (idx)
            REG_CX: cx = $signed(v);
            REG_CY: cy = $signed(v);
            REG_R:  rad = {33'd0, v[30:0]};
            REG_AS: ast = $signed(v[15:0]);
            REG_AE: aen = $signed(v[15:0]);
            default: ;
         endcase
      endfunction

      function logic signed [63:0] round_mul43(logic signed [63:0] m, logic signed [63:0] s);
         logic signed [63:0] mh, ml, hi, lo;
         mh = m >>> 24;
         ml = m - mh * 64'sd16777216;
         hi = mh * s;
         lo = ml * s + (64'sd1 <<< 42);
         return (hi + (lo >>> 24)) >>> 19;
      endfunction

      function void note_request(req_type rq);
         rsp_type e;
         logic signed [63:0] t, d, span, base, ang, z, x, y, dx, dy, m, mabs, sp;
         logic flip;
         t = rq.param_t;
         d = aen - ast;
         if (rq.op == OP_NONE) begin
            e = '0;
            pending = {pending, e};
            return;
         end
         if (rq.op == OP_SYM) begin
            span = d; base = (ast + aen) * 16384;
         end else if (rq.op == OP_FWD) begin
            span = 2 * d; base = ast * 32768;
         end else begin
            span = -2 * d; base = aen * 32768;
         end
         ang = t * span + base;
         z = ang % 64'sd843314857;
         if (z < 0) z += 64'sd843314857;
         if (z >= 64'sd421657428) z -= 64'sd843314857;
         flip = 0;
         if (z > 64'sd210828714) begin
            z -= 64'sd421657428; flip = 1;
         end else if (z < -64'sd210828714) begin
            z += 64'sd421657428; flip = 1;
         end
         x = 64'sd652032874; y = 0;
         for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
            dx = y >>> i; dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= atan_q27(i);
            end else begin
               x += dx; y -= dy; z += atan_q27(i);
            end
         end
         if (flip) begin
            x = -x; y = -y;
         end
         e.point_x = sat(cx + ((rad * x + (64'sd1 <<< 29)) >>> 30));
         e.point_y = sat(cy + ((rad * y + (64'sd1 <<< 29)) >>> 30));
         m = rad * span;
         mabs = m < 0 ? -m : m;
         sp = (mabs + 4096) >>> 13;
         if (sp > 64'sd2147483647) sp = 64'sd2147483647;
         e.speed = sp[30:0];
         if (rq.op == OP_REV && rq.negate_tangent) m = -m;
         e.tangent_x = sat(-round_mul43(m, y));
         e.tangent_y = sat(round_mul43(m, x));
         pending = {pending, e};
      endfunction

      function logic signed [63:0] atan_q27(int i);
         logic signed [63:0] tbl[10] = '{105414357, 62229729, 32880480, 16690645, 8377711,
                                         4192939, 2096981, 1048555, 524285, 262144};
         if (i < 10) return tbl[i];
         if (i <= 27) return 64'sd1 <<< (27 - i);
         return 0;
      endfunction

      function logic signed [31:0] sat(logic signed [63:0] v);
         if (v > 64'sd2147483647) return 32'h7fffffff;
         if (v < -64'sd2147483648) return 32'h80000000;
         return v[31:0];
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected response transaction");
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.point_x !== e.point_x) begin
            $error("point_x expected %0d actual %0d", e.point_x, got.point_x); errors++;
         end
         if (got.point_y !== e.point_y) begin
            $error("point_y expected %0d actual %0d", e.point_y, got.point_y); errors++;
         end
         if (got.tangent_x !== e.tangent_x) begin
            $error("tangent_x expected %0d actual %0d", e.tangent_x, got.tangent_x); errors++;
         end
         if (got.tangent_y !== e.tangent_y) begin
            $error("tangent_y expected %0d actual %0d", e.tangent_y, got.tangent_y); errors++;
         end
         if (got.speed !== e.speed) begin
            $error("speed expected %0d actual %0d", e.speed, got.speed); errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;
   cap_req_if req ();
   cap_rsp_if rsp ();

   arc_scoreboard sb = new();
   int req_idle_pct = 35;
   int rsp_idle_pct = 35;
   int hold_cycles = 0;
   bit hold_req = 0;
   bit hold_done = 0;

   circular_arc_point_and_tangent_core u_top (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   initial begin
      req.valid = 0;
      req.data = '0;
      rsp.ready = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready) sb.note_request(req.data);
         if (rsp.valid && rsp.ready) sb.check_result(rsp.data);
      end
   end

   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp.ready <= 0;
      end else if (hold_req && !hold_done) begin
         hold_cycles <= 3 * LAT + 20;
         hold_done <= 1;
         rsp.ready <= 0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic write_csr(logic [2:0] idx, logic [31:0] v);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      sb.write_reg(idx, v);
   endtask

   task automatic send(req_type rq);
      while ($urandom_range(99) < req_idle_pct) begin
         req.valid <= 0;
         @(posedge clock);
      end
      req.valid <= 1;
      req.data <= rq;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   task automatic drain();
      req.valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (LAT + 4) @(posedge clock);
   endtask

   function automatic req_type rand_req();
      req_type rq;
      rq.op = ($urandom_range(19) == 0) ? OP_NONE : 2'($urandom_range(2));
      case ($urandom_range(9))
         0: rq.param_t = 16'($urandom);
         1: rq.param_t = 16'sd16384;
         2: rq.param_t = -16'sd16384;
         default: rq.param_t = (rq.op == OP_SYM) ? 16'($urandom_range(32768) - 16384)
                                                  : 16'($urandom_range(16384));
      endcase
      rq.negate_tangent = 1'($urandom_range(1));
      return rq;
   endfunction

   task automatic random_config(int kind);
      case (kind)
         0: begin
            write_csr(REG_CX, 32'h7fffffff); write_csr(REG_CY, 32'h80000000);
            write_csr(REG_R, 32'h7fffffff); write_csr(REG_AS, 32'h8000);
            write_csr(REG_AE, 32'h7fff);
         end
         1: begin
            write_csr(REG_CX, 0); write_csr(REG_CY, 0);
            write_csr(REG_R, 0); write_csr(REG_AS, 32'h7fff);
            write_csr(REG_AE, 32'h8000);
         end
         default: begin
            write_csr(REG_CX, $urandom); write_csr(REG_CY, $urandom);
            write_csr(REG_R, $urandom_range(1) ? $urandom : $urandom_range(32'h40000));
            write_csr(REG_AS, $urandom); write_csr(REG_AE, $urandom);
            write_csr(3'($urandom_range(7, 5)), $urandom);
         end
      endcase
      csr_wr_en <= 0;
      @(posedge clock);
   endtask

   initial begin
      req_type rq;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (int op = 0; op < 4; op++) begin
         rq.op = 2'(op);
         rq.negate_tangent = 1'b1;
         rq.param_t = 16'sh8000; send(rq);
         rq.param_t = 16'sh7fff; send(rq);
         rq.param_t = 16'sd16384; send(rq);
         rq.param_t = -16'sd16384; send(rq);
         rq.param_t = '0; rq.negate_tangent = 1'b0; send(rq);
      end
      drain();
      random_config(0);
      for (int op = 0; op < 3; op++) begin
         rq.op = 2'(op); rq.negate_tangent = 1'($urandom_range(1));
         rq.param_t = 16'sd16384; send(rq);
         rq.param_t = 16'sh8000; send(rq);
      end
      drain();
      random_config(1);
      for (int i = 0; i < 200; i++) send(rand_req());
      drain();
      for (int ph = 0; ph < 6; ph++) begin
         random_config(2);
         if (ph == 2) begin
            req_idle_pct = 0; rsp_idle_pct = 0;
         end else begin
            req_idle_pct = 35; rsp_idle_pct = 35;
         end
         if (ph == 3) hold_req = 1;
         for (int i = 0; i < 200; i++) send(rand_req());
         drain();
      end
      if (sb.errors == 0) begin
         $display("circular_arc_point_and_tangent_core regression: pass");
      end else begin
         $display("circular_arc_point_and_tangent_core regression: fail");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("circular_arc_point_and_tangent_core regression: fail");
      $finish;
   end
endmodule

// ===== files.f =====
rtl/cap_pkg.sv
rtl/cap_if.sv
rtl/circular_arc_point_and_tangent_core.sv
sim/circular_arc_point_and_tangent_core_tb.sv
